FILE: hw/rtl/frh_pkg.sv
// frh_pkg: shared types and constants for the fixed range histogram
// used by frh_ctrl, frh_datapath and fixed_range_histogram; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frh_pkg;

  localparam int SMP_W  = 32;            // signed q16.16 sample and bounds
  localparam int NUM_W  = 7;             // bins_in_use register width
  localparam int STEP_W = 3;             // divider step counter, NUM_W steps
  localparam int PROD_W = SMP_W + NUM_W; // bins times offset
  localparam int HIT_W  = 6;             // bin index on the ports
  localparam int OCNT_W = 32;            // counts on the ports
  localparam int CIDX_W = 2;             // configuration register index

  localparam logic [CIDX_W-1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [NUM_W-1:0] BINS_RESET = 7'd64;
  localparam logic [SMP_W-1:0] HIGH_RESET = 32'h0001_0000;

  typedef enum logic [1:0] {
    MODE_ADD   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_CLR,
    ST_FIN
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic mul;
    logic div;
    logic rd;
    logic wr;
    logic clr;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    mode_t mode;
    logic  in_rng;
    logic  at_top;
    logic  div_last;
    logic  sweep_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/frh_datapath.sv
// frh_datapath: config registers, bin index multiply and divider, bin store
// and result registers; depends on frh_pkg, driven by frh_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module frh_datapath import frh_pkg::*; #(
  parameter int BINS       = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [SMP_W-1:0]  cfg_data,
  input  wire logic [1:0]        in_mode,
  input  wire logic [SMP_W-1:0]  in_sample,
  input  wire logic [HIT_W-1:0]  in_read_index,
  input  wire cmd_t              cmd,
  output stat_t                  stat,
  output logic                   out_in_range,
  output logic [HIT_W-1:0]       out_bin_hit,
  output logic [OCNT_W-1:0]      out_bin_count,
  output logic [OCNT_W-1:0]      out_total_count
);

  localparam int IDX_W = $clog2(BINS);

  logic signed [SMP_W-1:0] low_r;
  logic signed [SMP_W-1:0] high_r;
  logic [NUM_W-1:0]        bins_r;

  mode_t                   mode_r;
  logic signed [SMP_W-1:0] x_r;
  logic [HIT_W-1:0]        ridx_r;

  logic [PROD_W-1:0]       rem_r;
  logic [NUM_W-1:0]        q_r;
  logic [STEP_W-1:0]       step_r;

  logic [IDX_W-1:0]        sweep_r;
  logic [COUNT_BITS-1:0]   total_r;
  logic [COUNT_BITS-1:0]   rd_data_r;
  logic [COUNT_BITS-1:0]   mem [BINS];

  logic                    in_range_r;
  logic [HIT_W-1:0]        hit_r;
  logic [OCNT_W-1:0]       count_r;
  logic [OCNT_W-1:0]       total_out_r;

  logic [NUM_W-1:0]        n_eff;
  logic [SMP_W:0]          off_w;
  logic [SMP_W:0]          span_w;
  logic [PROD_W-1:0]       prod_w;
  logic [PROD_W-1:0]       dsh_w;
  logic [IDX_W-1:0]        bin_idx;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [COUNT_BITS-1:0]   wr_data;
  logic [COUNT_BITS-1:0]   cnt_inc;
  logic [COUNT_BITS-1:0]   tot_inc;
  logic                    rd_ok;
  logic                    add_hit;

  // bins in use clamped to one .. BINS
  always_comb begin
    if (bins_r == '0) begin
      n_eff = NUM_W'(1);
    end else if (32'(bins_r) > BINS) begin
      n_eff = NUM_W'(BINS);
    end else begin
      n_eff = bins_r;
    end
  end

  // offset and span are known non-negative and below 2^32 when used
  assign off_w  = {x_r[SMP_W-1], x_r} - {low_r[SMP_W-1], low_r};
  assign span_w = {high_r[SMP_W-1], high_r} - {low_r[SMP_W-1], low_r};
  assign prod_w = PROD_W'(n_eff) * PROD_W'(off_w[SMP_W-1:0]);
  assign dsh_w  = PROD_W'(span_w[SMP_W-1:0]) << step_r;

  assign stat.mode       = mode_r;
  assign stat.in_rng     = (high_r > low_r) && (x_r >= low_r) && (x_r <= high_r);
  assign stat.at_top     = (x_r == high_r);
  assign stat.div_last   = (step_r == '0);
  assign stat.sweep_last = (sweep_r == IDX_W'(BINS - 1));

  assign bin_idx = stat.at_top ? IDX_W'(n_eff - NUM_W'(1)) : IDX_W'(q_r);
  assign rd_addr = (mode_r == MODE_ADD) ? bin_idx : IDX_W'(ridx_r);
  assign cnt_inc = (&rd_data_r) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
  assign tot_inc = (&total_r) ? total_r : total_r + COUNT_BITS'(1);
  assign rd_ok   = (32'(ridx_r) < BINS);
  assign add_hit = (mode_r == MODE_ADD) && stat.in_rng;

  assign wr_en   = cmd.wr | cmd.clr;
  assign wr_addr = cmd.wr ? bin_idx : sweep_r;
  assign wr_data = cmd.wr ? cnt_inc : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      high_r <= HIGH_RESET;
      bins_r <= BINS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_LOW:   low_r  <= cfg_data;
        REG_RANGE_HIGH:  high_r <= cfg_data;
        REG_BINS_IN_USE: bins_r <= cfg_data[NUM_W-1:0];
        default: ;
      endcase
    end
  end

  // item capture and divider
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mode_r <= mode_t'(in_mode);
      x_r    <= in_sample;
      ridx_r <= in_read_index;
    end
    if (cmd.mul) begin
      rem_r  <= prod_w;
      q_r    <= '0;
      step_r <= STEP_W'(NUM_W - 1);
    end else if (cmd.div) begin
      if (rem_r >= dsh_w) begin
        rem_r <= rem_r - dsh_w;
        q_r   <= q_r | (NUM_W'(1) << step_r);
      end
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
      total_r <= '0;
    end else begin
      if (cmd.clr) begin
        sweep_r <= stat.sweep_last ? '0 : sweep_r + IDX_W'(1);
        total_r <= '0;
      end else if (cmd.wr) begin
        total_r <= tot_inc;
      end
    end
  end

  // bin store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      in_range_r  <= add_hit;
      total_out_r <= OCNT_W'(total_r);
      if (add_hit) begin
        hit_r   <= HIT_W'(bin_idx);
        count_r <= OCNT_W'(cnt_inc);
      end else if (mode_r == MODE_READ) begin
        hit_r   <= ridx_r;
        count_r <= rd_ok ? OCNT_W'(rd_data_r) : '0;
      end else begin
        hit_r   <= '0;
        count_r <= '0;
      end
    end
  end

  assign out_in_range    = in_range_r;
  assign out_bin_hit     = hit_r;
  assign out_bin_count   = count_r;
  assign out_total_count = total_out_r;

  a_idx_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (32'(bin_idx) < 32'(n_eff)))
    else $error("bin index beyond bins in use");

  a_total_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> (total_r != '0))
    else $error("total not counted after bin update");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr && cmd.clr))
    else $error("bin update during clear sweep");

endmodule

`default_nettype wire

FILE: hw/rtl/frh_ctrl.sv
// frh_ctrl: sequencer for the histogram, one item at a time
// depends on frh_pkg; drives frh_datapath through cmd_t, reads stat_t
`timescale 1ns / 1ps
`default_nettype none

module frh_ctrl import frh_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.clr = 1'b1;
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISP;
        end
      end
      ST_DISP: begin
        case (stat.mode)
          MODE_ADD: begin
            if (!stat.in_rng) begin
              state_nxt = ST_FIN;
            end else if (stat.at_top) begin
              state_nxt = ST_RD;
            end else begin
              cmd.mul   = 1'b1;
              state_nxt = ST_DIV;
            end
          end
          MODE_READ:  state_nxt = ST_RD;
          MODE_CLEAR: state_nxt = ST_CLR;
          default:    state_nxt = ST_FIN;
        endcase
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (stat.div_last) state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = (stat.mode == MODE_ADD) ? ST_WR : ST_FIN;
      end
      ST_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (stat.sweep_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while item in flight");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrites unread output");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_range_histogram.sv
// fixed_range_histogram: top level, uniform bin histogram over a q16.16 range
// depends on frh_pkg, frh_ctrl and frh_datapath
//
//   channel  signals                                          direction
//   in       in_valid/in_ready, in_mode, in_sample,           sink
//            in_read_index
//   out      out_valid/out_ready, out_in_range, out_bin_hit,  source
//            out_bin_count, out_total_count
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         sink, always ready
//
// an add in range goes through the 7-step restoring divider, then a read and a
// write of the bin store; an add at the top edge skips the divider, an add out
// of range and a no-op skip the bin store, and a read only reads it
// a clear sweeps the bin store; after reset the same sweep runs before the
// first input is taken
// a finished result waits in the output register; a stall there holds the
// next item in its final step
`timescale 1ns / 1ps
`default_nettype none

module fixed_range_histogram import frh_pkg::*; #(
  parameter int BINS       = 64,
  parameter int COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [SMP_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_mode,
  input  wire logic [SMP_W-1:0]  in_sample,
  input  wire logic [HIT_W-1:0]  in_read_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_in_range,
  output logic [HIT_W-1:0]       out_bin_hit,
  output logic [OCNT_W-1:0]      out_bin_count,
  output logic [OCNT_W-1:0]      out_total_count
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  frh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  frh_datapath #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_mode         (in_mode),
    .in_sample       (in_sample),
    .in_read_index   (in_read_index),
    .cmd             (cmd),
    .stat            (stat),
    .out_in_range    (out_in_range),
    .out_bin_hit     (out_bin_hit),
    .out_bin_count   (out_bin_count),
    .out_total_count (out_total_count)
  );

endmodule

`default_nettype wire

FILE: dv/fixed_range_histogram_tb.sv
// fixed_range_histogram_tb: self-checking bench for the uniform bin histogram
// drives add, clear, read and no-op transactions against a local bin model
// depends on frh_pkg and fixed_range_histogram
`timescale 1ns / 1ps

module fixed_range_histogram_tb;
  import frh_pkg::*;

  localparam int NUM_BINS    = 64;
  localparam int IDLE_PCT    = 32;
  localparam int SETTLE      = 100;      // covers a clear sweep plus the longest item
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_ITEMS = 127;

  typedef struct {
    mode_t             mode;
    logic signed [31:0] sample;
    logic [HIT_W-1:0]   read_index;
  } hist_op_t;

  typedef struct {
    logic              in_range;
    logic [HIT_W-1:0]  bin_hit;
    logic [OCNT_W-1:0] bin_count;
    logic [OCNT_W-1:0] total_count;
  } hist_result_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index;
  logic [SMP_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_mode;
  logic [SMP_W-1:0]    in_sample;
  logic [HIT_W-1:0]    in_read_index;
  logic                out_valid;
  logic                out_ready;
  logic                out_in_range;
  logic [HIT_W-1:0]    out_bin_hit;
  logic [OCNT_W-1:0]   out_bin_count;
  logic [OCNT_W-1:0]   out_total_count;

  // local copy of the configuration and the bin store
  logic signed [31:0]  cur_low;
  logic signed [31:0]  cur_high;
  logic [NUM_W-1:0]    cur_bins;
  logic [31:0]         bin_tally [NUM_BINS];
  logic [31:0]         tally_total;

  hist_op_t            op_queue [$];
  hist_result_t        awaited_results [$];
  hist_op_t            cur_op;
  hist_result_t        want;

  logic                steady;
  logic                squeezed;
  int                  stall_left;
  int                  results_seen;
  int                  fail_count;
  int                  cycles;

  fixed_range_histogram #(
    .BINS      (NUM_BINS),
    .COUNT_BITS(32)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_sample      (in_sample),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_in_range   (out_in_range),
    .out_bin_hit    (out_bin_hit),
    .out_bin_count  (out_bin_count),
    .out_total_count(out_total_count)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [31:0] sat_bump(logic [31:0] c);
    return (c == '1) ? c : c + 32'd1;
  endfunction

  // updates the local bin store and returns the result the block should give
  function automatic hist_result_t histogram_step(hist_op_t op);
    hist_result_t       r;
    logic signed [63:0] x;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [63:0]        span;
    logic [63:0]        off;
    logic [63:0]        n;
    logic [63:0]        idx;
    r  = '{default: '0};
    x  = 64'(op.sample);
    lo = 64'(cur_low);
    hi = 64'(cur_high);
    case (op.mode)
      MODE_ADD: begin
        if (hi > lo && x >= lo && x <= hi) begin
          n = 64'(cur_bins);
          if (n == 0) n = 64'd1;
          if (n > NUM_BINS) n = 64'(NUM_BINS);
          if (x == hi) begin
            idx = n - 64'd1;
          end else begin
            span = hi - lo;
            off  = x - lo;
            idx  = (n * off) / span;
            if (idx >= n) idx = n - 64'd1;
          end
          bin_tally[idx] = sat_bump(bin_tally[idx]);
          tally_total    = sat_bump(tally_total);
          r.in_range  = 1'b1;
          r.bin_hit   = idx[HIT_W-1:0];
          r.bin_count = bin_tally[idx];
        end
      end
      MODE_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        tally_total = '0;
      end
      MODE_READ: begin
        r.bin_hit   = op.read_index;
        r.bin_count = bin_tally[op.read_index];
      end
      default: ;
    endcase
    r.total_count = tally_total;
    return r;
  endfunction

  function automatic hist_op_t random_op();
    hist_op_t           op;
    int                 pick;
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic [63:0]        span;
    logic [63:0]        pos;
    pick          = $urandom_range(99);
    op.read_index = HIT_W'($urandom_range(63));
    op.sample     = $urandom;
    if (pick < 70) op.mode = MODE_ADD;
    else if (pick < 90) op.mode = MODE_READ;
    else if (pick < 98) op.mode = MODE_NOP;
    else op.mode = MODE_CLEAR;
    lo   = 64'(cur_low);
    hi   = 64'(cur_high);
    pick = $urandom_range(99);
    if (pick < 75) begin
      if (hi > lo) begin
        span      = hi - lo;
        pos       = lo + ({$urandom, $urandom} % (span + 64'd1));
        op.sample = pos[31:0];
      end
    end else if (pick < 82) begin
      op.sample = cur_low;
    end else if (pick < 88) begin
      op.sample = cur_high;
    end else if (pick < 92) begin
      op.sample = cur_high + 32'sd1;
    end else if (pick < 95) begin
      op.sample = cur_low - 32'sd1;
    end
    return op;
  endfunction

  task automatic push_op(mode_t mode, logic [31:0] sample, logic [HIT_W-1:0] ridx);
    hist_op_t op;
    op.mode       = mode;
    op.sample     = sample;
    op.read_index = ridx;
    op_queue.push_back(op);
  endtask

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_RANGE_LOW:   cur_low  = data;
      REG_RANGE_HIGH:  cur_high = data;
      REG_BINS_IN_USE: cur_bins = data[NUM_W-1:0];
      default: ;
    endcase
  endtask

  // waits until every queued transaction has its result, then lets the block settle
  // sampled mid-cycle so the driver's updates of the same edge are seen
  task automatic drain();
    do @(negedge clk);
    while (op_queue.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_config();
    logic signed [63:0] lo;
    logic signed [63:0] hi;
    logic signed [63:0] t;
    logic [31:0]        bins_word;
    int                 pick;
    pick = $urandom_range(3);
    case (pick)
      0: begin
        lo = 64'($signed($urandom));
        hi = 64'($signed($urandom));
        if (lo > hi && $urandom_range(99) < 80) begin
          t  = lo;
          lo = hi;
          hi = t;
        end
      end
      1: begin
        lo = -64'sd2147483648;
        hi = 64'sd2147483647;
      end
      2: begin
        lo = 64'($signed($urandom));
        hi = lo + 64'($urandom_range(1, 300));
        if (hi > 64'sd2147483647) begin
          hi = 64'sd2147483647;
          lo = hi - 64'($urandom_range(1, 300));
        end
      end
      default: begin
        lo = 64'sd0;
        hi = 64'sd65536;
      end
    endcase
    bins_word = ($urandom_range(99) < 30) ? $urandom : 32'd0;
    pick = $urandom_range(5);
    case (pick)
      0: bins_word[NUM_W-1:0] = 7'd1;
      1: bins_word[NUM_W-1:0] = 7'd64;
      2: bins_word[NUM_W-1:0] = 7'd127;
      3: bins_word[NUM_W-1:0] = 7'd0;
      4: bins_word[NUM_W-1:0] = NUM_W'($urandom_range(65, 127));
      default: bins_word[NUM_W-1:0] = NUM_W'($urandom_range(1, 64));
    endcase
    write_reg(REG_RANGE_LOW, lo[31:0]);
    write_reg(REG_RANGE_HIGH, hi[31:0]);
    write_reg(REG_BINS_IN_USE, bins_word);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) awaited_results.push_back(histogram_step(cur_op));
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cur_op = op_queue.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= cur_op.mode;
          in_sample     <= cur_op.sample;
          in_read_index <= cur_op.read_index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_in_range !== want.in_range) begin
            $error("in_range: expected %0d, got %0d", want.in_range, out_in_range);
            fail_count++;
          end
          if (out_bin_hit !== want.bin_hit) begin
            $error("bin_hit: expected %0d, got %0d", want.bin_hit, out_bin_hit);
            fail_count++;
          end
          if (out_bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, got %0d", want.bin_count, out_bin_count);
            fail_count++;
          end
          if (out_total_count !== want.total_count) begin
            $error("total_count: expected %0d, got %0d", want.total_count, out_total_count);
            fail_count++;
          end
        end
        results_seen++;
      end
      // one long receiver hold-off so the input side backs up
      if (!squeezed && results_seen == 150) begin
        squeezed   = 1'b1;
        stall_left = 400;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_mode       = '0;
    in_sample     = '0;
    in_read_index = '0;
    out_ready     = 1'b0;
    steady        = 1'b0;
    squeezed      = 1'b0;
    stall_left    = 0;
    results_seen  = 0;
    fail_count    = 0;
    cycles        = 0;
    cur_low       = 32'sd0;
    cur_high      = HIGH_RESET;
    cur_bins      = BINS_RESET;
    tally_total   = '0;
    foreach (bin_tally[i]) bin_tally[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // reset range 0..1.0 over 64 bins: edges, top edge, out of range
    push_op(MODE_READ,  32'h0, 6'd0);
    push_op(MODE_ADD,   32'h0000_0000, 6'h3F);
    push_op(MODE_ADD,   32'h0001_0000, 6'd0);
    push_op(MODE_ADD,   32'h0000_FFFF, 6'd0);
    push_op(MODE_ADD,   32'hFFFF_FFFF, 6'd0);
    push_op(MODE_ADD,   32'h0001_0001, 6'd0);
    push_op(MODE_ADD,   32'h7FFF_FFFF, 6'd0);
    push_op(MODE_ADD,   32'h8000_0000, 6'd0);
    push_op(MODE_READ,  32'h0, 6'd63);
    push_op(MODE_NOP,   32'hA5A5_A5A5, 6'h2A);
    push_op(MODE_CLEAR, 32'h0, 6'd0);
    push_op(MODE_READ,  32'h0, 6'd63);
    push_op(MODE_ADD,   32'h0000_8000, 6'd0);
    drain();

    // full signed span in one bin
    write_reg(REG_RANGE_LOW, 32'h8000_0000);
    write_reg(REG_RANGE_HIGH, 32'h7FFF_FFFF);
    write_reg(REG_BINS_IN_USE, 32'd1);
    push_op(MODE_ADD,  32'h8000_0000, 6'd0);
    push_op(MODE_ADD,  32'h7FFF_FFFF, 6'd0);
    push_op(MODE_ADD,  32'h0000_0000, 6'd0);
    push_op(MODE_READ, 32'h0, 6'd0);
    drain();

    // zero bins acts as one, oversized count acts as the full store
    write_reg(REG_BINS_IN_USE, 32'd0);
    push_op(MODE_ADD,  32'd12345, 6'd0);
    drain();
    write_reg(REG_BINS_IN_USE, 32'hFFFF_FF7F);
    push_op(MODE_ADD,  32'h8000_0000, 6'd0);
    push_op(MODE_ADD,  32'h7FFF_FFFF, 6'd0);
    push_op(MODE_ADD,  32'hFFFF_FFFF, 6'd0);
    push_op(MODE_READ, 32'h0, 6'd63);
    drain();

    // empty range, then inverted range: nothing counts
    write_reg(REG_RANGE_LOW, 32'd5);
    write_reg(REG_RANGE_HIGH, 32'd5);
    push_op(MODE_ADD,  32'd5, 6'd0);
    drain();
    write_reg(REG_RANGE_HIGH, 32'd4);
    push_op(MODE_ADD,  32'd4, 6'd0);
    push_op(MODE_ADD,  32'd5, 6'd0);
    push_op(MODE_READ, 32'h0, 6'd0);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_config();
      steady = (ph == 5);
      repeat (PHASE_ITEMS) op_queue.push_back(random_op());
      drain();
      steady = 1'b0;
    end

    if (awaited_results.size() != 0) begin
      $error("%0d expected results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
